### rtl/awm_pkg.sv
// Shared types and constants for the anagram window match block.
// Holds the input mode codes, the work item passed from front to back, and defaults.
// Used by every module of the block but awm_ram; depends on nothing.
package awm_pkg;

  localparam int DEF_MAX_PATTERN = 256;
  localparam int DEF_ALPHABET    = 128;
  localparam int SYMBOL_W        = 7;
  localparam int POS_W           = 32;
  localparam int MODE_W          = 2;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_LOAD,
    KIND_TEXT
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [SYMBOL_W-1:0] sym;
    logic [SYMBOL_W-1:0] old_sym;
    logic                leave;
    logic                full_after;
    logic [POS_W-1:0]    start;
  } work_item_t;

endpackage

### rtl/awm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module awm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/awm_front.sv
// Front end of the anagram window match block: accepts items and classifies them.
// Tracks pattern length, window fill, ring pointer and text position, and keeps the text ring.
// Depends on awm_pkg and awm_ram.
module awm_front import awm_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int ALPHABET    = DEF_ALPHABET
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [SYMBOL_W-1:0] symbol,
  input  logic                q_full,
  output logic                fo_valid,
  output work_item_t          fo_item
);

  localparam int PLW = $clog2(MAX_PATTERN + 1);
  localparam int LW  = PLW + 1;
  localparam int RW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [PLW-1:0]      pattern_length, pattern_length_next;
  logic [PLW-1:0]      window_fill, window_fill_next;
  logic [RW-1:0]       ring_ptr, ring_ptr_next, old_slot;
  logic [LW-1:0]       ptr_ext, plen_ext, old_slot_ext;
  logic                text_seen, text_seen_next;
  logic [POS_W-1:0]    text_position, text_position_next;
  work_item_t          fo_desc, fo_desc_next;
  logic                fo_load, fo_push, accept;
  logic                ring_we, ring_re, sym_ok, leave, full_after;
  logic [SYMBOL_W-1:0] ring_rdata;

  assign fo_push    = fo_valid && !q_full;
  assign item_stall = fo_valid && q_full;
  assign accept     = item_valid && !item_stall;
  assign sym_ok     = int'(symbol) < ALPHABET;

  assign ptr_ext      = LW'(ring_ptr);
  assign plen_ext     = LW'(pattern_length);
  assign old_slot_ext = (ptr_ext >= plen_ext) ? (ptr_ext - plen_ext)
                                              : (ptr_ext + LW'(MAX_PATTERN) - plen_ext);
  assign old_slot     = RW'(old_slot_ext);
  assign leave        = window_fill == pattern_length;
  assign full_after   = leave || ((window_fill + PLW'(1)) == pattern_length);

  always_comb begin
    pattern_length_next = pattern_length;
    window_fill_next    = window_fill;
    ring_ptr_next       = ring_ptr;
    text_seen_next      = text_seen;
    text_position_next  = text_position;
    fo_load             = 1'b0;
    ring_we             = 1'b0;
    ring_re             = 1'b0;
    fo_desc_next.kind       = KIND_TEXT;
    fo_desc_next.sym        = symbol;
    fo_desc_next.old_sym    = '0;
    fo_desc_next.leave      = leave;
    fo_desc_next.full_after = full_after;
    fo_desc_next.start      = text_position - POS_W'(pattern_length) + POS_W'(1);
    if (accept) begin
      unique case (mode)
        MODE_CLEAR: begin
          pattern_length_next = '0;
          window_fill_next    = '0;
          ring_ptr_next       = '0;
          text_seen_next      = 1'b0;
          text_position_next  = '0;
          fo_load             = 1'b1;
          fo_desc_next.kind   = KIND_CLEAR;
        end
        MODE_PATTERN: begin
          if (!text_seen && sym_ok && (pattern_length < PLW'(MAX_PATTERN))) begin
            pattern_length_next = pattern_length + PLW'(1);
            fo_load             = 1'b1;
            fo_desc_next.kind   = KIND_LOAD;
          end
        end
        MODE_TEXT: begin
          text_seen_next     = 1'b1;
          text_position_next = text_position + POS_W'(1);
          if (pattern_length != '0) begin
            fo_load       = 1'b1;
            ring_we       = 1'b1;
            ring_re       = leave;
            ring_ptr_next = (ring_ptr == RW'(MAX_PATTERN - 1)) ? '0 : ring_ptr + RW'(1);
            if (!leave) begin
              window_fill_next = window_fill + PLW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      window_fill    <= '0;
      ring_ptr       <= '0;
      text_seen      <= 1'b0;
      text_position  <= '0;
      fo_valid       <= 1'b0;
    end else begin
      pattern_length <= pattern_length_next;
      window_fill    <= window_fill_next;
      ring_ptr       <= ring_ptr_next;
      text_seen      <= text_seen_next;
      text_position  <= text_position_next;
      if (fo_load) begin
        fo_valid <= 1'b1;
      end else if (fo_push) begin
        fo_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fo_load) begin
      fo_desc <= fo_desc_next;
    end
  end

  always_comb begin
    fo_item         = fo_desc;
    fo_item.old_sym = ring_rdata;
  end

  awm_ram #(
    .WIDTH(SYMBOL_W),
    .DEPTH(MAX_PATTERN)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ring_ptr),
    .wdata(symbol),
    .re   (ring_re),
    .raddr(old_slot),
    .rdata(ring_rdata)
  );

endmodule

### rtl/awm_queue.sv
// Short FIFO of work items between the front end and the table stage.
// Depth is the package constant QUEUE_DEPTH, a power of two.
// Depends on awm_pkg.
module awm_queue import awm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  work_item_t push_item,
  output logic       full,
  output logic       head_valid,
  output work_item_t head_item,
  input  logic       pop
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  work_item_t     entries [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign full       = count == (QAW + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (QAW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

### rtl/awm_back.sv
// Table stage of the anagram window match block: updates the symbol balances and the
// unmatched count, and holds the result register. Balances are kept as two counter tables
// (pattern loads plus departures, and arrivals). Depends on awm_pkg and awm_ram.
module awm_back import awm_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int ALPHABET    = DEF_ALPHABET
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  work_item_t       q_item,
  output logic             q_pop,
  output logic             match_valid,
  input  logic             match_stall,
  output logic [POS_W-1:0] window_start
);

  localparam int AW = $clog2(ALPHABET);
  localparam int UW = $clog2(MAX_PATTERN + 1);
  localparam int BW = UW + 1;

  logic                b1_valid, b1_fire, pop;
  work_item_t          b1_item;
  logic [AW-1:0]       hd_addr_a, hd_addr_b, b1_addr_a, b1_addr_b;
  logic [BW-1:0]       plus_rd_a, plus_rd_b, minus_rd_a, minus_rd_b;
  logic [ALPHABET-1:0] plus_vld, minus_vld;
  logic                fwp_en, fwm_en;
  logic [AW-1:0]       fwp_addr, fwm_addr;
  logic [BW-1:0]       fwp_data, fwm_data;
  logic [BW-1:0]       pa, pb, ma, mb, po1, pb_eff, bal_old, bal_new;
  logic                old_ok, new_ok, old_act, new_act, inc, dec, is_match;
  logic                plus_we, minus_we;
  logic [BW-1:0]       plus_wdata, minus_wdata;
  logic [UW-1:0]       unmatched, unmatched_next;

  assign b1_fire = b1_valid && (!match_valid || !match_stall);
  assign pop     = q_valid && (!b1_valid || b1_fire);
  assign q_pop   = pop;

  assign hd_addr_a = (q_item.kind == KIND_LOAD) ? AW'(q_item.sym) : AW'(q_item.old_sym);
  assign hd_addr_b = AW'(q_item.sym);
  assign b1_addr_a = (b1_item.kind == KIND_LOAD) ? AW'(b1_item.sym) : AW'(b1_item.old_sym);
  assign b1_addr_b = AW'(b1_item.sym);

  // The previous item's writes land at the same edge as this item's reads.
  assign pa = (fwp_en && (fwp_addr == b1_addr_a)) ? fwp_data
            : (plus_vld[b1_addr_a] ? plus_rd_a : '0);
  assign pb = (fwp_en && (fwp_addr == b1_addr_b)) ? fwp_data
            : (plus_vld[b1_addr_b] ? plus_rd_b : '0);
  assign ma = (fwm_en && (fwm_addr == b1_addr_a)) ? fwm_data
            : (minus_vld[b1_addr_a] ? minus_rd_a : '0);
  assign mb = (fwm_en && (fwm_addr == b1_addr_b)) ? fwm_data
            : (minus_vld[b1_addr_b] ? minus_rd_b : '0);

  assign old_ok  = int'(b1_item.old_sym) < ALPHABET;
  assign new_ok  = int'(b1_item.sym) < ALPHABET;
  assign old_act = b1_item.leave && old_ok;
  assign new_act = new_ok;

  assign po1     = pa + BW'(1);
  assign bal_old = po1 - ma;
  assign pb_eff  = (old_act && (b1_addr_a == b1_addr_b)) ? po1 : pb;
  assign bal_new = pb_eff - mb;

  always_comb begin
    inc            = 1'b0;
    dec            = 1'b0;
    is_match       = 1'b0;
    plus_we        = 1'b0;
    minus_we       = 1'b0;
    plus_wdata     = po1;
    minus_wdata    = mb + BW'(1);
    unmatched_next = unmatched;
    unique case (b1_item.kind)
      KIND_CLEAR: begin
        unmatched_next = '0;
      end
      KIND_LOAD: begin
        plus_we        = b1_fire;
        unmatched_next = unmatched + UW'(1);
      end
      KIND_TEXT: begin
        inc            = old_act && !bal_old[BW-1] && (bal_old != '0);
        dec            = new_act && !bal_new[BW-1] && (bal_new != '0);
        plus_we        = b1_fire && old_act;
        minus_we       = b1_fire && new_act;
        unmatched_next = unmatched + UW'(inc) - UW'(dec);
        is_match       = b1_item.full_after && (unmatched_next == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid    <= 1'b0;
      unmatched   <= '0;
      plus_vld    <= '0;
      minus_vld   <= '0;
      fwp_en      <= 1'b0;
      fwm_en      <= 1'b0;
      match_valid <= 1'b0;
    end else begin
      if (pop) begin
        b1_valid <= 1'b1;
        fwp_en   <= plus_we;
        fwm_en   <= minus_we;
      end else if (b1_fire) begin
        b1_valid <= 1'b0;
      end
      if (b1_fire) begin
        unmatched <= unmatched_next;
        if (b1_item.kind == KIND_CLEAR) begin
          plus_vld  <= '0;
          minus_vld <= '0;
        end else begin
          if (plus_we) begin
            plus_vld[b1_addr_a] <= 1'b1;
          end
          if (minus_we) begin
            minus_vld[b1_addr_b] <= 1'b1;
          end
        end
      end
      if (b1_fire && is_match) begin
        match_valid <= 1'b1;
      end else if (!match_stall) begin
        match_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_item  <= q_item;
      fwp_addr <= b1_addr_a;
      fwp_data <= plus_wdata;
      fwm_addr <= b1_addr_b;
      fwm_data <= minus_wdata;
    end
    if (b1_fire && is_match) begin
      window_start <= b1_item.start;
    end
  end

  awm_ram #(.WIDTH(BW), .DEPTH(ALPHABET)) u_plus_a (
    .clk(clk), .we(plus_we), .waddr(b1_addr_a), .wdata(plus_wdata),
    .re(pop), .raddr(hd_addr_a), .rdata(plus_rd_a)
  );

  awm_ram #(.WIDTH(BW), .DEPTH(ALPHABET)) u_plus_b (
    .clk(clk), .we(plus_we), .waddr(b1_addr_a), .wdata(plus_wdata),
    .re(pop), .raddr(hd_addr_b), .rdata(plus_rd_b)
  );

  awm_ram #(.WIDTH(BW), .DEPTH(ALPHABET)) u_minus_a (
    .clk(clk), .we(minus_we), .waddr(b1_addr_b), .wdata(minus_wdata),
    .re(pop), .raddr(hd_addr_a), .rdata(minus_rd_a)
  );

  awm_ram #(.WIDTH(BW), .DEPTH(ALPHABET)) u_minus_b (
    .clk(clk), .we(minus_we), .waddr(b1_addr_b), .wdata(minus_wdata),
    .re(pop), .raddr(hd_addr_b), .rdata(minus_rd_b)
  );

endmodule

### rtl/anagram_window_match.sv
// Sliding-window anagram search. Mode 0 clears the block, mode 1 loads a pattern character
// and mode 2 feeds a text character; whenever the last P text characters are a permutation
// of the pattern, the start position of that window comes out as one transfer. Every item,
// including a clear, is pipelined at one item per clock unless stalled; a match passes
// the front, queue and table-stage registers into the result register. Throughput is set
// by the balance tables' read-modify-write, closed by forwarding the previous write. A
// four-entry queue decouples input from the result side, so input keeps flowing while a
// result is held until the queue fills. Clearing uses per-symbol valid bits and needs no
// sweep. Depends on awm_pkg, awm_front, awm_queue, awm_back and awm_ram.
module anagram_window_match import awm_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int ALPHABET    = DEF_ALPHABET
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [SYMBOL_W-1:0] symbol,
  output logic                match_valid,
  input  logic                match_stall,
  output logic [POS_W-1:0]    window_start
);

  logic       fo_valid, q_push, q_full, q_valid, q_pop;
  work_item_t fo_item, q_item;

  assign q_push = fo_valid && !q_full;

  awm_front #(
    .MAX_PATTERN(MAX_PATTERN),
    .ALPHABET   (ALPHABET)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .mode      (mode),
    .symbol    (symbol),
    .q_full    (q_full),
    .fo_valid  (fo_valid),
    .fo_item   (fo_item)
  );

  awm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (fo_item),
    .full      (q_full),
    .head_valid(q_valid),
    .head_item (q_item),
    .pop       (q_pop)
  );

  awm_back #(
    .MAX_PATTERN(MAX_PATTERN),
    .ALPHABET   (ALPHABET)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .match_valid (match_valid),
    .match_stall (match_stall),
    .window_start(window_start)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !match_valid && !q_valid)
    else $error("Result or queue not empty after reset.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("Table stage popped an empty queue.");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst) q_full |-> q_valid)
    else $error("Queue reports full without a head item.");

endmodule

### sim/anagram_window_match_tb.sv
// Self-checking testbench for anagram_window_match: a directed table, one long-pattern
// episode and randomized pattern/text episodes under varied idle and stall pressure.
// Depends on awm_pkg and the anagram_window_match RTL.
module anagram_window_match_tb;
  import awm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int MAXP = DEF_MAX_PATTERN;
  localparam int ALPHA = DEF_ALPHABET;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SYMBOL_W-1:0] sym;
    logic                typed;
    logic                hit;
    logic [POS_W-1:0]    start;
  } table_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [MODE_W-1:0]   mode = MODE_CLEAR;
  logic [SYMBOL_W-1:0] symbol = '0;
  logic                match_valid;
  logic                match_stall = 1'b0;
  logic [POS_W-1:0]    window_start;

  logic signed [9:0] balance [0:ALPHA];
  logic [7:0]        ring_sym [0:MAXP-1];
  logic [8:0]        pat_len;
  logic [8:0]        open_cnt;
  logic [8:0]        fill;
  logic [7:0]        wr_ptr;
  logic [POS_W-1:0]  text_pos;
  logic              text_started;

  logic [POS_W-1:0] start_q [$];
  logic [POS_W-1:0] next_start;
  int errors = 0;
  int sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  table_row_t dir_rows [25] = '{
    '{MODE_TEXT,    7'h41, 1'b1, 1'b0, 32'd0},
    '{MODE_CLEAR,   7'h00, 1'b1, 1'b0, 32'd0},
    '{MODE_PATTERN, 7'h00, 1'b0, 1'b0, 32'd0},
    '{MODE_PATTERN, 7'h7F, 1'b0, 1'b0, 32'd0},
    '{MODE_PATTERN, 7'h7F, 1'b0, 1'b0, 32'd0},
    '{MODE_TEXT,    7'h7F, 1'b1, 1'b0, 32'd0},
    '{MODE_TEXT,    7'h00, 1'b1, 1'b0, 32'd0},
    '{MODE_TEXT,    7'h7F, 1'b1, 1'b1, 32'd0},
    '{MODE_PATTERN, 7'h05, 1'b0, 1'b0, 32'd0},
    '{MODE_UNUSED,  7'h7F, 1'b0, 1'b0, 32'd0},
    '{MODE_TEXT,    7'h7F, 1'b1, 1'b1, 32'd1},
    '{MODE_TEXT,    7'h01, 1'b0, 1'b0, 32'd0},
    '{MODE_CLEAR,   7'h7F, 1'b1, 1'b0, 32'd0},
    '{MODE_PATTERN, 7'h55, 1'b0, 1'b0, 32'd0},
    '{MODE_PATTERN, 7'h2A, 1'b0, 1'b0, 32'd0},
    '{MODE_TEXT,    7'h2A, 1'b0, 1'b0, 32'd0},
    '{MODE_TEXT,    7'h55, 1'b1, 1'b1, 32'd0},
    '{MODE_TEXT,    7'h55, 1'b0, 1'b0, 32'd0},
    '{MODE_TEXT,    7'h2A, 1'b1, 1'b1, 32'd2},
    '{MODE_CLEAR,   7'h00, 1'b1, 1'b0, 32'd0},
    '{MODE_PATTERN, 7'h01, 1'b0, 1'b0, 32'd0},
    '{MODE_TEXT,    7'h01, 1'b1, 1'b1, 32'd0},
    '{MODE_TEXT,    7'h01, 1'b1, 1'b1, 32'd1},
    '{MODE_UNUSED,  7'h00, 1'b0, 1'b0, 32'd0},
    '{MODE_CLEAR,   7'h00, 1'b1, 1'b0, 32'd0}
  };

  anagram_window_match u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .symbol       (symbol),
    .match_valid  (match_valid),
    .match_stall  (match_stall),
    .window_start (window_start)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("anagram_window_match_tb failed");
    $finish;
  end

  function automatic void clear_window();
    for (int i = 0; i <= ALPHA; i++) balance[i] = '0;
    for (int i = 0; i < MAXP; i++) ring_sym[i] = '0;
    pat_len = '0;
    open_cnt = '0;
    fill = '0;
    wr_ptr = '0;
    text_pos = '0;
    text_started = 1'b0;
  endfunction

  function automatic void window_step(input logic [MODE_W-1:0] m, input logic [SYMBOL_W-1:0] s,
                                      output logic hit, output logic [POS_W-1:0] start);
    logic [7:0] idx;
    logic [7:0] old;
    logic [7:0] slot;
    logic [POS_W-1:0] here;
    hit = 1'b0;
    start = '0;
    idx = (s < ALPHA) ? 8'(s) : 8'(ALPHA);
    case (m)
      MODE_CLEAR: clear_window();
      MODE_PATTERN: begin
        if (!text_started && idx < ALPHA && pat_len < MAXP) begin
          balance[idx] = balance[idx] + 10'sd1;
          pat_len = pat_len + 9'd1;
          open_cnt = open_cnt + 9'd1;
        end
      end
      MODE_TEXT: begin
        text_started = 1'b1;
        here = text_pos;
        text_pos = text_pos + POS_W'(1);
        if (pat_len != 0) begin
          if (fill >= pat_len) begin
            slot = wr_ptr - pat_len[7:0];
            old = ring_sym[slot];
            balance[old] = balance[old] + 10'sd1;
            if (balance[old] > 0) open_cnt = open_cnt + 9'd1;
          end else begin
            fill = fill + 9'd1;
          end
          if (balance[idx] > 0) open_cnt = open_cnt - 9'd1;
          balance[idx] = balance[idx] - 10'sd1;
          ring_sym[wr_ptr] = idx;
          wr_ptr = wr_ptr + 8'd1;
          if (fill >= pat_len && open_cnt == 0) begin
            hit = 1'b1;
            start = here - POS_W'(pat_len) + POS_W'(1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    match_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && match_valid && !match_stall) begin
      if (start_q.size() == 0) begin
        $error("window_start: expected none, actual %0d", window_start);
        errors++;
      end else begin
        next_start = start_q.pop_front();
        if (window_start !== next_start) begin
          $error("window_start: expected %0d, actual %0d", next_start, window_start);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] m, input logic [SYMBOL_W-1:0] s,
                           input logic typed, input logic typed_hit,
                           input logic [POS_W-1:0] typed_start);
    logic hit;
    logic [POS_W-1:0] start;
    while ($urandom_range(99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    symbol <= s;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    window_step(m, s, hit, start);
    if (typed) begin
      hit = typed_hit;
      start = typed_start;
    end
    if (hit) start_q = {start_q, start};
    if (m != MODE_UNUSED) sent++;
  endtask

  task automatic feed(input logic [MODE_W-1:0] m, input logic [SYMBOL_W-1:0] s);
    send_item(m, s, 1'b0, 1'b0, '0);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (start_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic shuffle_syms(ref logic [SYMBOL_W-1:0] q [$]);
    int j;
    logic [SYMBOL_W-1:0] t;
    for (int k = q.size() - 1; k > 0; k--) begin
      j = $urandom_range(k, 0);
      t = q[k];
      q[k] = q[j];
      q[j] = t;
    end
  endtask

  task automatic long_episode();
    logic [SYMBOL_W-1:0] pat [$];
    logic [SYMBOL_W-1:0] c;
    feed(MODE_CLEAR, '0);
    for (int i = 0; i < MAXP + 2; i++) begin
      c = SYMBOL_W'($urandom_range(127, 0));
      if (i < MAXP) pat = {pat, c};
      feed(MODE_PATTERN, c);
    end
    shuffle_syms(pat);
    foreach (pat[i]) feed(MODE_TEXT, pat[i]);
    repeat (3) feed(MODE_TEXT, SYMBOL_W'($urandom_range(127, 0)));
  endtask

  task automatic run_episode();
    logic [SYMBOL_W-1:0] pat [$];
    logic [SYMBOL_W-1:0] chunk [$];
    logic [SYMBOL_W-1:0] base;
    logic [SYMBOL_W-1:0] c;
    int span;
    int plen;
    int tlen;
    int n;
    int r;
    base = SYMBOL_W'($urandom_range(127, 0));
    span = $urandom_range(4, 1);
    r = $urandom_range(99);
    plen = (r < 5) ? 0 : (r < 20) ? $urandom_range(40, 9) : $urandom_range(8, 1);
    if ($urandom_range(9) != 0) feed(MODE_CLEAR, SYMBOL_W'($urandom_range(127, 0)));
    for (int i = 0; i < plen; i++) begin
      c = base + SYMBOL_W'($urandom_range(span - 1, 0));
      pat = {pat, c};
      feed(MODE_PATTERN, c);
    end
    tlen = plen * $urandom_range(4, 2) + $urandom_range(6, 1);
    n = 0;
    while (n < tlen) begin
      r = $urandom_range(99);
      if (r < 45 && plen > 0) begin
        chunk = pat;
        shuffle_syms(chunk);
        foreach (chunk[i]) feed(MODE_TEXT, chunk[i]);
        n += plen;
      end else if (r < 88) begin
        feed(MODE_TEXT, base + SYMBOL_W'($urandom_range(span - 1, 0)));
        n++;
      end else if (r < 94) begin
        feed(MODE_TEXT, SYMBOL_W'($urandom_range(127, 0)));
        n++;
      end else if (r < 97) begin
        feed(MODE_UNUSED, SYMBOL_W'($urandom_range(127, 0)));
      end else begin
        feed(MODE_PATTERN, SYMBOL_W'($urandom_range(127, 0)));
        n++;
      end
    end
  endtask

  initial begin
    int gap_set [4];
    int stall_set [4];
    gap_set = '{0, 54, 0, 33};
    stall_set = '{0, 0, 54, 33};
    clear_window();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].mode, dir_rows[i].sym, dir_rows[i].typed, dir_rows[i].hit,
                dir_rows[i].start);
    end
    drain();
    gap_pct = 33;
    stall_pct = 33;
    long_episode();
    drain();
    sent = 0;
    for (int p = 0; p < 4; p++) begin
      gap_pct = gap_set[p];
      stall_pct = stall_set[p];
      while (sent < (p + 1) * 25) run_episode();
      drain();
    end
    if (start_q.size() != 0) begin
      $error("window_start: %0d expected transfers never arrived", start_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("anagram_window_match_tb passed");
    end else begin
      $display("anagram_window_match_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/awm_pkg.sv
rtl/awm_ram.sv
rtl/awm_front.sv
rtl/awm_queue.sv
rtl/awm_back.sv
rtl/anagram_window_match.sv
sim/anagram_window_match_tb.sv
